// File: hw/rtl/ilt_pkg.sv
`timescale 1ns / 1ps

package ilt_pkg;

  localparam int unsigned MAX_LINE = 8192;

  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_HASH    = 8'h23;
  localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  localparam logic [1:0] KIND_SECTION = 2'd0;
  localparam logic [1:0] KIND_KEY     = 2'd1;
  localparam logic [1:0] KIND_VALUE   = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  localparam logic [3:0] VERDICT_IGNORED    = 4'd0;
  localparam logic [3:0] VERDICT_SECTION    = 4'd1;
  localparam logic [3:0] VERDICT_PROPERTY   = 4'd2;
  localparam logic [3:0] VERDICT_NO_BRACKET = 4'd3;
  localparam logic [3:0] VERDICT_TRAILING   = 4'd4;
  localparam logic [3:0] VERDICT_NO_EQUALS  = 4'd5;
  localparam logic [3:0] VERDICT_BAD_START  = 4'd6;
  localparam logic [3:0] VERDICT_TOO_LONG   = 4'd7;
  localparam logic [3:0] VERDICT_INCOMPLETE = 4'd8;

  typedef enum logic [4:0] {
    MODE_LEAD    = 5'b00001,
    MODE_IGNORE  = 5'b00010,
    MODE_SECTION = 5'b00100,
    MODE_PROP    = 5'b01000,
    MODE_BAD     = 5'b10000
  } line_mode_e;

  typedef struct packed {
    logic       op;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic [3:0] verdict;
    logic       is_error;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

  function automatic logic is_alnum(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_error_verdict(logic [3:0] v);
    return (v >= VERDICT_NO_BRACKET) && (v <= VERDICT_BAD_START);
  endfunction

endpackage

// File: hw/rtl/ilt_stream_if.sv
`timescale 1ns / 1ps

interface ilt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ini_line_tokenizer.sv
`timescale 1ns / 1ps
// An accepted input word is held in the input register and, if it makes a result, moves on
// to the result register; words that make no result vanish in the input register.
// Throughput: one input word per cycle; input stalls only if a held result meets a new one.
// Reset: rst_ni clears the line state, the halt flag and both valid flags at once.
// After an error verdict the block swallows all input until the next reset.

module ini_line_tokenizer #(
  parameter int unsigned MaxLine = ilt_pkg::MAX_LINE
) (
  input logic         clk_i,
  input logic         rst_ni,
  ilt_stream_if.sink   in_i,
  ilt_stream_if.source out_o
);

  logic               s1_valid_q;
  ilt_pkg::in_item_t  s1_data_q;
  logic               out_valid_q;
  ilt_pkg::out_item_t out_data_q;
  ilt_pkg::step_res_t res;
  logic               s1_go;

  // The staged word moves on unless it makes a result and the result register is stuck.
  assign s1_go      = s1_valid_q && (!res.valid || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;

  ilt_line_fsm #(
    .MaxLine(MaxLine)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(s1_valid_q),
    .item_i      (s1_data_q),
    .step_i      (s1_go),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_data_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && res.valid) begin
      out_data_q <= res.item;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// File: hw/rtl/ilt_line_fsm.sv
`timescale 1ns / 1ps

module ilt_line_fsm #(
  parameter int unsigned MaxLine = ilt_pkg::MAX_LINE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  ilt_pkg::in_item_t  item_i,
  input  logic               step_i,
  output ilt_pkg::step_res_t res_o
);

  localparam int unsigned LenW = $clog2(MaxLine + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(MaxLine);

  ilt_pkg::line_mode_e mode_q, mode_d;
  logic [LenW-1:0]     len_q, len_d;
  logic                delim_q, delim_d;
  logic                trail_q, trail_d;
  logic                halted_q, halted_d;

  logic [LenW-1:0] len_inc;
  logic            room;
  logic [3:0]      line_verdict;
  logic [7:0]      b;

  assign b       = item_i.text_byte;
  assign len_inc = (len_q < LenMax) ? len_q + LenW'(1) : len_q;
  assign room    = len_inc < LenMax;

  always_comb begin
    if (len_q >= LenMax) begin
      line_verdict = ilt_pkg::VERDICT_TOO_LONG;
    end else begin
      unique case (mode_q)
        ilt_pkg::MODE_SECTION: begin
          if (!delim_q)     line_verdict = ilt_pkg::VERDICT_NO_BRACKET;
          else if (trail_q) line_verdict = ilt_pkg::VERDICT_TRAILING;
          else              line_verdict = ilt_pkg::VERDICT_SECTION;
        end
        ilt_pkg::MODE_PROP: begin
          line_verdict = delim_q ? ilt_pkg::VERDICT_PROPERTY : ilt_pkg::VERDICT_NO_EQUALS;
        end
        ilt_pkg::MODE_BAD: line_verdict = ilt_pkg::VERDICT_BAD_START;
        default:           line_verdict = ilt_pkg::VERDICT_IGNORED;
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    delim_d  = delim_q;
    trail_d  = trail_q;
    halted_d = halted_q;
    res_o    = '0;

    if (item_valid_i && !halted_q) begin
      if (item_i.op) begin
        // End of stream flushes a partial line only if it has any bytes.
        if (len_q != '0) begin
          mode_d  = ilt_pkg::MODE_LEAD;
          len_d   = '0;
          delim_d = 1'b0;
          trail_d = 1'b0;
          res_o.valid        = 1'b1;
          res_o.item.kind    = ilt_pkg::KIND_VERDICT;
          res_o.item.verdict = ilt_pkg::VERDICT_INCOMPLETE;
        end
      end else if (b == ilt_pkg::CHAR_NUL) begin
        res_o.valid = 1'b0;
      end else if (b == ilt_pkg::CHAR_NEWLINE) begin
        mode_d   = ilt_pkg::MODE_LEAD;
        len_d    = '0;
        delim_d  = 1'b0;
        trail_d  = 1'b0;
        halted_d = ilt_pkg::is_error_verdict(line_verdict);
        res_o.valid         = 1'b1;
        res_o.item.kind     = ilt_pkg::KIND_VERDICT;
        res_o.item.verdict  = line_verdict;
        res_o.item.is_error = ilt_pkg::is_error_verdict(line_verdict);
      end else begin
        len_d = len_inc;
        res_o.item.token_byte = b;
        unique case (mode_q)
          ilt_pkg::MODE_LEAD: begin
            priority if (b == ilt_pkg::CHAR_SPACE || b == ilt_pkg::CHAR_TAB) begin
              mode_d = ilt_pkg::MODE_LEAD;
            end else if (b == ilt_pkg::CHAR_SEMI || b == ilt_pkg::CHAR_HASH) begin
              mode_d = ilt_pkg::MODE_IGNORE;
            end else if (b == ilt_pkg::CHAR_LBRACK) begin
              mode_d = ilt_pkg::MODE_SECTION;
            end else if (ilt_pkg::is_alnum(b)) begin
              mode_d = ilt_pkg::MODE_PROP;
              res_o.valid     = room;
              res_o.item.kind = ilt_pkg::KIND_KEY;
            end else begin
              mode_d = ilt_pkg::MODE_BAD;
            end
          end
          ilt_pkg::MODE_SECTION: begin
            priority if (delim_q) begin
              trail_d = 1'b1;
            end else if (b == ilt_pkg::CHAR_RBRACK) begin
              delim_d = 1'b1;
            end else begin
              res_o.valid     = room;
              res_o.item.kind = ilt_pkg::KIND_SECTION;
            end
          end
          ilt_pkg::MODE_PROP: begin
            if (!delim_q && b == ilt_pkg::CHAR_EQUALS) begin
              delim_d = 1'b1;
            end else begin
              res_o.valid     = room;
              res_o.item.kind = delim_q ? ilt_pkg::KIND_VALUE : ilt_pkg::KIND_KEY;
            end
          end
          default: res_o.valid = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ilt_pkg::MODE_LEAD;
      len_q    <= '0;
      delim_q  <= 1'b0;
      trail_q  <= 1'b0;
      halted_q <= 1'b0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      len_q    <= len_d;
      delim_q  <= delim_d;
      trail_q  <= trail_d;
      halted_q <= halted_d;
    end
  end

  // Once halted, only reset brings the block back.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared without reset");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid && res_o.item.is_error) |=> halted_q)
    else $error("error verdict did not halt the block");

  a_quiet_when_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_o.valid)
    else $error("result produced while halted");

  a_len_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax)
    else $error("line length ran past its limit");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ilt_pkg::*;

  localparam int unsigned LINE_LIMIT = MAX_LINE;

  // Tracks the tokenizer's line state and holds the result words it should produce.
  class line_tracker;
    line_mode_e  mode = MODE_LEAD;
    int unsigned len = 0;
    bit          past_delim = 0;
    bit          trailing = 0;
    bit          halted = 0;
    out_item_t   expected_words [$];
    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    int unsigned verdict_tally [16];

    function void clear_line();
      mode = MODE_LEAD;
      len = 0;
      past_delim = 0;
      trailing = 0;
    endfunction

    function void push_word(logic [1:0] kind, logic [7:0] tok, logic [3:0] verdict);
      out_item_t w;
      w.kind = kind;
      w.token_byte = tok;
      w.verdict = verdict;
      w.is_error = (kind == KIND_VERDICT) && (verdict >= VERDICT_NO_BRACKET) &&
                   (verdict <= VERDICT_BAD_START);
      if (kind == KIND_VERDICT) verdict_tally[verdict]++;
      expected_words.push_back(w);
    endfunction

    function void accept_word(in_item_t w);
      logic [7:0] b;
      logic [3:0] v;
      bit         emit;
      b = w.text_byte;
      if (halted) return;
      if (w.op) begin
        if (len != 0) begin
          clear_line();
          push_word(KIND_VERDICT, 8'h00, VERDICT_INCOMPLETE);
        end
        return;
      end
      if (b == CHAR_NUL) return;
      if (b == CHAR_NEWLINE) begin
        if (len >= LINE_LIMIT) begin
          v = VERDICT_TOO_LONG;
        end else begin
          case (mode)
            MODE_SECTION: v = !past_delim ? VERDICT_NO_BRACKET :
                              (trailing ? VERDICT_TRAILING : VERDICT_SECTION);
            MODE_PROP:    v = past_delim ? VERDICT_PROPERTY : VERDICT_NO_EQUALS;
            MODE_BAD:     v = VERDICT_BAD_START;
            default:      v = VERDICT_IGNORED;
          endcase
        end
        clear_line();
        if (v >= VERDICT_NO_BRACKET && v <= VERDICT_BAD_START) halted = 1;
        push_word(KIND_VERDICT, 8'h00, v);
        return;
      end
      if (len < LINE_LIMIT) len++;
      emit = (len < LINE_LIMIT);
      case (mode)
        MODE_LEAD: begin
          if (b == CHAR_SPACE || b == CHAR_TAB) begin
          end else if (b == CHAR_SEMI || b == CHAR_HASH) begin
            mode = MODE_IGNORE;
          end else if (b == CHAR_LBRACK) begin
            mode = MODE_SECTION;
          end else if (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
            mode = MODE_PROP;
            if (emit) push_word(KIND_KEY, b, VERDICT_IGNORED);
          end else begin
            mode = MODE_BAD;
          end
        end
        MODE_SECTION: begin
          if (past_delim) trailing = 1;
          else if (b == CHAR_RBRACK) past_delim = 1;
          else if (emit) push_word(KIND_SECTION, b, VERDICT_IGNORED);
        end
        MODE_PROP: begin
          if (!past_delim && b == CHAR_EQUALS) past_delim = 1;
          else if (emit) push_word(past_delim ? KIND_VALUE : KIND_KEY, b, VERDICT_IGNORED);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual kind %0d byte %0h verdict %0d error %0b",
                 $time, got.kind, got.token_byte, got.verdict, got.is_error);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("token_byte", want.token_byte, got.token_byte);
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("is_error", want.is_error, got.is_error);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned words_in;
  int unsigned phase_end;
  line_tracker line_check;

  ilt_stream_if #(.payload_t(in_item_t))  in_if ();
  ilt_stream_if #(.payload_t(out_item_t)) out_if ();

  ini_line_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Results are checked before the input word of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) line_check.check_word(out_if.data);
      if (in_if.valid && in_if.ready) begin
        line_check.accept_word(in_if.data);
        words_in++;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [7:0] pick_text(logic [7:0] banned, bit nul_ok);
    logic [7:0] b;
    if (nul_ok && $urandom_range(39) == 0) return CHAR_NUL;
    do b = 8'($urandom_range(255, 1)); while (b == CHAR_NEWLINE || b == banned);
    return b;
  endfunction

  function automatic logic [7:0] pick_alnum();
    int unsigned r;
    r = $urandom_range(61);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 36) return 8'(8'h41 + r - 10);
    return 8'(8'h61 + r - 36);
  endfunction

  task automatic send_word(input logic eos, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{op: eos, text_byte: b};
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic send_chars(input logic [7:0] chars [$]);
    foreach (chars[i]) send_word(1'b0, chars[i]);
  endtask

  task automatic send_blanks(input int unsigned max_count);
    repeat ($urandom_range(max_count)) send_word(1'b0, $urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (line_check.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Lines near or past the length limit; the content of a too-long line does not matter.
  task automatic send_long_line(input int unsigned count, input bit as_section);
    send_word(1'b0, as_section ? CHAR_LBRACK : pick_alnum());
    for (int unsigned k = 1; k < count; k++) begin
      if (as_section) send_word(1'b0, pick_text(CHAR_RBRACK, 0));
      else if (k == 40) send_word(1'b0, CHAR_EQUALS);
      else send_word(1'b0, pick_text(k < 40 ? CHAR_EQUALS : CHAR_NEWLINE, 0));
    end
    send_word(1'b0, CHAR_NEWLINE);
  endtask

  task automatic send_random_line();
    int unsigned pick;
    bit          cut;
    pick = $urandom_range(99);
    cut = ($urandom_range(19) == 0);
    send_blanks(2);
    if (pick < 30) begin
      send_word(1'b0, pick_alnum());
      repeat ($urandom_range(5)) send_word(1'b0, pick_text(CHAR_EQUALS, 1));
      send_word(1'b0, CHAR_EQUALS);
      repeat ($urandom_range(10)) send_word(1'b0, pick_text(CHAR_NEWLINE, 1));
    end else if (pick < 50) begin
      send_word(1'b0, CHAR_LBRACK);
      repeat ($urandom_range(8)) send_word(1'b0, pick_text(CHAR_RBRACK, 1));
      send_word(1'b0, CHAR_RBRACK);
    end else if (pick < 65) begin
      send_word(1'b0, $urandom_range(1) ? CHAR_SEMI : CHAR_HASH);
      repeat ($urandom_range(10)) send_word(1'b0, pick_text(CHAR_NEWLINE, 1));
    end else if (pick >= 75) begin
      // Arbitrary bytes are always cut off by an end of stream, so no error verdict arises.
      repeat ($urandom_range(6)) send_word(1'b0, pick_text(CHAR_NEWLINE, 1));
      cut = 1;
    end
    if (cut) send_word(1'b1, 8'($urandom_range(255)));
    else send_word(1'b0, CHAR_NEWLINE);
  endtask

  // An error verdict halts the block for good, so exactly one error line ends the stimulus.
  task automatic send_error_line();
    logic [3:0] which;
    logic [7:0] b;
    which = 4'(VERDICT_NO_BRACKET + $urandom_range(3));
    send_blanks(2);
    case (which)
      VERDICT_NO_BRACKET: begin
        send_word(1'b0, CHAR_LBRACK);
        repeat ($urandom_range(4)) send_word(1'b0, pick_text(CHAR_RBRACK, 1));
      end
      VERDICT_TRAILING: begin
        send_word(1'b0, CHAR_LBRACK);
        repeat ($urandom_range(4)) send_word(1'b0, pick_text(CHAR_RBRACK, 1));
        send_word(1'b0, CHAR_RBRACK);
        repeat ($urandom_range(3, 1)) send_word(1'b0, pick_text(CHAR_NEWLINE, 0));
      end
      VERDICT_NO_EQUALS: begin
        send_word(1'b0, pick_alnum());
        repeat ($urandom_range(4)) send_word(1'b0, pick_text(CHAR_EQUALS, 1));
      end
      default: begin
        do b = pick_text(CHAR_NEWLINE, 0);
        while (b inside {CHAR_SPACE, CHAR_TAB, CHAR_SEMI, CHAR_HASH, CHAR_LBRACK,
                         [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
        send_word(1'b0, b);
        repeat ($urandom_range(4)) send_word(1'b0, pick_text(CHAR_NEWLINE, 1));
      end
    endcase
    send_word(1'b0, CHAR_NEWLINE);
  endtask

  initial begin
    line_check = new;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    words_in = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Blank line, end of stream at a line start, extreme section bytes, property with
    // further '=' in the value, two comment lines, cut-off line with a zero byte, empty section.
    send_chars('{CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE});
    send_word(1'b1, 8'hFF);
    send_chars('{CHAR_LBRACK, 8'h01, 8'hFF, CHAR_RBRACK, CHAR_NEWLINE});
    send_chars('{8'h30, 8'h7A, CHAR_EQUALS, 8'h41, CHAR_EQUALS, 8'hFF, CHAR_NEWLINE});
    send_chars('{CHAR_SEMI, CHAR_LBRACK, CHAR_NEWLINE, CHAR_HASH, CHAR_NEWLINE});
    send_chars('{8'h5A, CHAR_NUL, 8'h39});
    send_word(1'b1, 8'h00);
    send_chars('{CHAR_LBRACK, CHAR_RBRACK, CHAR_NEWLINE});
    wait_for_results();

    send_long_line(LINE_LIMIT - 1, 0);
    send_long_line(LINE_LIMIT, 0);
    send_long_line(LINE_LIMIT + $urandom_range(40), 1);
    wait_for_results();

    phase_end = words_in + 490;
    while (words_in < phase_end) send_random_line();
    wait_for_results();

    set_idling(58, 0);
    phase_end = words_in + 490;
    while (words_in < phase_end) send_random_line();
    wait_for_results();

    set_idling(0, 58);
    phase_end = words_in + 490;
    while (words_in < phase_end) send_random_line();
    wait_for_results();

    set_idling(8, 8);
    phase_end = words_in + 490;
    while (words_in < phase_end) send_random_line();
    send_error_line();
    // The halted block swallows everything from here on.
    repeat (20) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
    wait_for_results();

    $display("Run covered %0d input words and %0d result words; verdicts: %0d section, %0d property,",
             words_in, line_check.words_checked, line_check.verdict_tally[VERDICT_SECTION],
             line_check.verdict_tally[VERDICT_PROPERTY]);
    $display("  %0d ignored, %0d too long, %0d incomplete, then one error line that halted the block.",
             line_check.verdict_tally[VERDICT_IGNORED], line_check.verdict_tally[VERDICT_TOO_LONG],
             line_check.verdict_tally[VERDICT_INCOMPLETE]);
    if (line_check.mismatches == 0 && line_check.expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ilt_pkg.sv
hw/rtl/ilt_stream_if.sv
hw/rtl/ilt_line_fsm.sv
hw/rtl/ini_line_tokenizer.sv
bench/tb_top.sv
